// ===== hdl/ctiu_pkg.sv =====
package ctiu_pkg;

    localparam int CLOCK_RATIO = 8;
    localparam int PRELOAD_W = 16;
    localparam int ONE_SHOT_SCALE = CLOCK_RATIO * 16;
    localparam int PERIODIC_SCALE = CLOCK_RATIO;
    localparam int TICK_W = $clog2(ONE_SHOT_SCALE * ((1 << PRELOAD_W) - 1) + 1);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_ACK   = 2'd3
    } cmd_t;

    localparam logic [3:0] OFF_ACR      = 4'h4;
    localparam logic [3:0] OFF_MASK     = 4'h5;
    localparam logic [3:0] OFF_PRE_HI   = 4'h6;
    localparam logic [3:0] OFF_PRE_LO   = 4'h7;
    localparam logic [3:0] OFF_VECTOR   = 4'hc;
    localparam logic [3:0] OFF_ONE      = 4'he;
    localparam logic [3:0] OFF_IACK     = 4'hf;

    localparam logic [2:0] MODE_ONE_SHOT = 3'd3;
    localparam logic [2:0] MODE_PERIODIC = 3'd6;

    localparam int MASK_TIMER_BIT = 3;
    localparam logic [7:0] STATUS_TIMER = 8'h08;
    localparam logic [7:0] READ_ONE     = 8'h01;
    localparam logic [7:0] READ_UNUSED  = 8'hff;

    typedef struct packed {
        cmd_t       command;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_active;
    } out_item_t;

    typedef struct packed {
        logic expire;
    } timer_status_t;

endpackage

// ===== hdl/ctiu_timer.sv =====
module ctiu_timer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  ctiu_pkg::in_item_t     item,
    output ctiu_pkg::timer_status_t status
);

    logic [ctiu_pkg::TICK_W-1:0]    remaining_reg, remaining_next;
    logic [ctiu_pkg::TICK_W-1:0]    reload_reg, reload_next;
    logic [ctiu_pkg::PRELOAD_W-1:0] preload_reg, preload_next;
    logic                           running_reg, running_next;
    logic                           periodic_reg, periodic_next;
    logic                           expire;
    logic [2:0]                     mode;
    logic [ctiu_pkg::TICK_W-1:0]    preload_ext;

    assign mode        = item.write_data[6:4];
    assign preload_ext = ctiu_pkg::TICK_W'(preload_reg);

    always_comb
    begin
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        preload_next   = preload_reg;
        running_next   = running_reg;
        periodic_next  = periodic_reg;
        expire         = 1'b0;
        if (step)
        begin
            case (item.command)
                ctiu_pkg::CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (remaining_reg <= ctiu_pkg::TICK_W'(1))
                        begin
                            expire = 1'b1;
                            if (periodic_reg)
                                remaining_next = reload_reg;
                            else
                            begin
                                remaining_next = '0;
                                running_next   = 1'b0;
                            end
                        end
                        else
                            remaining_next = remaining_reg - ctiu_pkg::TICK_W'(1);
                    end
                end
                ctiu_pkg::CMD_WRITE:
                begin
                    if (item.reg_offset == ctiu_pkg::OFF_ACR)
                    begin
                        if (mode == ctiu_pkg::MODE_ONE_SHOT)
                        begin
                            periodic_next  = 1'b0;
                            running_next   = 1'b1;
                            remaining_next = preload_ext
                                * ctiu_pkg::TICK_W'(ctiu_pkg::ONE_SHOT_SCALE);
                        end
                        else if (mode == ctiu_pkg::MODE_PERIODIC)
                        begin
                            periodic_next  = 1'b1;
                            running_next   = 1'b1;
                            reload_next    = preload_ext
                                * ctiu_pkg::TICK_W'(ctiu_pkg::PERIODIC_SCALE);
                            remaining_next = reload_next;
                        end
                    end
                    else if (item.reg_offset == ctiu_pkg::OFF_PRE_HI)
                        preload_next = {item.write_data, preload_reg[7:0]};
                    else if (item.reg_offset == ctiu_pkg::OFF_PRE_LO)
                        preload_next = {preload_reg[15:8], item.write_data};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            reload_reg    <= '0;
            preload_reg   <= '0;
            running_reg   <= 1'b0;
            periodic_reg  <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            reload_reg    <= reload_next;
            preload_reg   <= preload_next;
            running_reg   <= running_next;
            periodic_reg  <= periodic_next;
        end
    end

    assign status.expire = expire;

endmodule

// ===== hdl/ctiu_intr.sv =====
module ctiu_intr (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  ctiu_pkg::in_item_t      item,
    input  ctiu_pkg::timer_status_t timer,
    output ctiu_pkg::out_item_t     result
);

    logic [7:0] mask_reg, mask_next;
    logic [7:0] vec_reg, vec_next;
    logic       flag_reg, flag_next;
    logic       irq_reg, irq_next;
    logic [7:0] rd;

    always_comb
    begin
        mask_next = mask_reg;
        vec_next  = vec_reg;
        flag_next = flag_reg;
        irq_next  = irq_reg;
        rd        = '0;
        if (step && timer.expire && mask_reg[ctiu_pkg::MASK_TIMER_BIT])
        begin
            irq_next  = 1'b1;
            flag_next = 1'b1;
        end
        case (item.command)
            ctiu_pkg::CMD_TICK:
            begin
            end
            ctiu_pkg::CMD_WRITE:
            begin
                if (step && item.reg_offset == ctiu_pkg::OFF_MASK)
                    mask_next = item.write_data;
                if (step && item.reg_offset == ctiu_pkg::OFF_VECTOR)
                    vec_next = item.write_data;
            end
            ctiu_pkg::CMD_READ:
            begin
                if (item.reg_offset == ctiu_pkg::OFF_MASK)
                begin
                    rd = flag_reg ? ctiu_pkg::STATUS_TIMER : 8'h00;
                    if (step)
                        flag_next = 1'b0;
                end
                else if (item.reg_offset == ctiu_pkg::OFF_ONE)
                    rd = ctiu_pkg::READ_ONE;
                else if (item.reg_offset == ctiu_pkg::OFF_IACK)
                begin
                    if (step)
                        irq_next = 1'b0;
                end
                else
                    rd = ctiu_pkg::READ_UNUSED;
            end
            ctiu_pkg::CMD_ACK:
                rd = vec_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            vec_reg  <= '0;
            flag_reg <= 1'b0;
            irq_reg  <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            vec_reg  <= vec_next;
            flag_reg <= flag_next;
            irq_reg  <= irq_next;
        end
    end

    assign result.read_data  = rd;
    assign result.irq_active = irq_next;

endmodule

// ===== hdl/counter_timer_interrupt_unit_core.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_item  (command, reg_offset, write_data)
// out     | out_valid / out_ready| out_item (read_data, irq_active)
//
// One transaction per cycle sustained while results are taken; an accepted input
// passes the input register, then the result register, where out_valid rises.
// The timer and interrupt state advance as an item leaves the input register.
// Reset clears the valid flags and all timer and interrupt state; the timer is stopped and the line deasserted.
// A stalled result holds the input register, which still takes a new item
// when it is empty.
module counter_timer_interrupt_unit_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ctiu_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ctiu_pkg::out_item_t out_item
);

    logic                    stage_valid_reg;
    ctiu_pkg::in_item_t      stage_item_reg;
    logic                    out_valid_reg;
    ctiu_pkg::out_item_t     out_item_reg;
    logic                    advance;
    logic                    step;
    ctiu_pkg::timer_status_t timer_status;
    ctiu_pkg::out_item_t     result;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = stage_valid_reg && advance;
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_item_reg <= in_item;
        if (step)
            out_item_reg <= result;
    end

    ctiu_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_item_reg),
        .status (timer_status)
    );

    ctiu_intr u_intr (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_item_reg),
        .timer  (timer_status),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== hdl/ctiu_checker.sv =====
module ctiu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ctiu_pkg::out_item_t out_item
);

    // back-pressure only while a result is stalled
    a_ready_only_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    // an accepted transaction is followed by a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("no result two cycles after acceptance");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped before acceptance");

    a_out_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_item))
        else $error("out_item changed while stalled");

endmodule

bind counter_timer_interrupt_unit_core ctiu_checker u_ctiu_checker (.*);

// ===== tb/sv/tb_counter_timer_interrupt_unit_core.sv =====
`timescale 1ns / 100ps

module tb_counter_timer_interrupt_unit_core;

    localparam int TOTAL_ITEMS = 550;
    localparam int DRAIN_CYCLES = 8;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    ctiu_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    ctiu_pkg::out_item_t out_item;

    counter_timer_interrupt_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    ctiu_pkg::in_item_t  pending_items[$];
    ctiu_pkg::out_item_t expected_results[$];
    ctiu_pkg::out_item_t predicted_result;
    ctiu_pkg::out_item_t expected_head;
    int                  items_sent = 0;
    int                  total_items = 0;
    int                  error_count = 0;

    // timer / interrupt state as seen by the predictor
    logic [ctiu_pkg::TICK_W-1:0] ticks_left = '0;
    logic [ctiu_pkg::TICK_W-1:0] reload_period = '0;
    logic                        timer_on = 1'b0;
    logic                        timer_periodic = 1'b0;
    logic [15:0]                 preload = '0;
    logic [7:0]                  mask_reg = '0;
    logic                        status_flag = 1'b0;
    logic [7:0]                  vector_value = '0;
    logic                        irq_line = 1'b0;

    task automatic timer_model_step(input ctiu_pkg::in_item_t it,
                                    output ctiu_pkg::out_item_t res);
        logic [7:0] rd;
        rd = '0;
        case (it.command)
            ctiu_pkg::CMD_TICK:
                if (timer_on)
                begin
                    if (ticks_left <= 1)
                    begin
                        ticks_left = '0;
                        if (timer_periodic)
                            ticks_left = reload_period;
                        else
                            timer_on = 1'b0;
                        if (mask_reg[ctiu_pkg::MASK_TIMER_BIT])
                        begin
                            irq_line = 1'b1;
                            status_flag = 1'b1;
                        end
                    end
                    else
                    begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            ctiu_pkg::CMD_WRITE:
                case (it.reg_offset)
                    ctiu_pkg::OFF_ACR:
                        if (it.write_data[6:4] == ctiu_pkg::MODE_ONE_SHOT)
                        begin
                            timer_periodic = 1'b0;
                            timer_on = 1'b1;
                            ticks_left = ctiu_pkg::TICK_W'(ctiu_pkg::ONE_SHOT_SCALE * preload);
                        end
                        else if (it.write_data[6:4] == ctiu_pkg::MODE_PERIODIC)
                        begin
                            timer_periodic = 1'b1;
                            timer_on = 1'b1;
                            reload_period =
                                ctiu_pkg::TICK_W'(ctiu_pkg::PERIODIC_SCALE * preload);
                            ticks_left = reload_period;
                        end
                    ctiu_pkg::OFF_MASK:   mask_reg = it.write_data;
                    ctiu_pkg::OFF_PRE_HI: preload[15:8] = it.write_data;
                    ctiu_pkg::OFF_PRE_LO: preload[7:0] = it.write_data;
                    ctiu_pkg::OFF_VECTOR: vector_value = it.write_data;
                    default: ;
                endcase
            ctiu_pkg::CMD_READ:
                case (it.reg_offset)
                    ctiu_pkg::OFF_MASK:
                    begin
                        rd = status_flag ? ctiu_pkg::STATUS_TIMER : 8'h00;
                        status_flag = 1'b0;
                    end
                    ctiu_pkg::OFF_ONE:  rd = ctiu_pkg::READ_ONE;
                    ctiu_pkg::OFF_IACK:
                    begin
                        rd = 8'h00;
                        irq_line = 1'b0;
                    end
                    default:  rd = ctiu_pkg::READ_UNUSED;
                endcase
            ctiu_pkg::CMD_ACK: rd = vector_value;
            default: ;
        endcase
        res.read_data = rd;
        res.irq_active = irq_line;
    endtask

    task automatic queue_item(input ctiu_pkg::cmd_t c, input logic [3:0] off,
                              input logic [7:0] d);
        ctiu_pkg::in_item_t it;
        it.command = c;
        it.reg_offset = off;
        it.write_data = d;
        pending_items.push_back(it);
    endtask

    task automatic queue_noise();
        queue_item(ctiu_pkg::cmd_t'($urandom_range(3)), 4'($urandom), 8'($urandom));
    endtask

    // ticks with the odd read or acknowledge cycle mixed in
    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                queue_item($urandom_range(1) ? ctiu_pkg::CMD_READ : ctiu_pkg::CMD_ACK,
                           4'($urandom), 8'($urandom));
            queue_item(ctiu_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
        end
    endtask

    task automatic queue_timer_start(input bit make_periodic, input logic [7:0] lo);
        logic [7:0] acr;
        acr = 8'($urandom);
        acr[6:4] = make_periodic ? ctiu_pkg::MODE_PERIODIC : ctiu_pkg::MODE_ONE_SHOT;
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_HI, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_LO, lo);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, acr);
    endtask

    function automatic int run_phase();
        int p;
        if (total_items == 0)
            return 0;
        p = items_sent * 4 / total_items;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic int sender_idle_pct();
        case (run_phase())
            1:       return 80;
            3:       return 24;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (run_phase())
            2:       return 80;
            3:       return 24;
            default: return 0;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                timer_model_step(in_item, predicted_result);
                expected_results.push_back(predicted_result);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction read_data=%02h irq_active=%0b",
                             $time, out_item.read_data, out_item.irq_active);
                    error_count++;
                end
                else
                begin
                    expected_head = expected_results.pop_front();
                    if (out_item.read_data !== expected_head.read_data)
                    begin
                        $display("%0t: read_data mismatch expected=%02h actual=%02h",
                                 $time, expected_head.read_data, out_item.read_data);
                        error_count++;
                    end
                    if (out_item.irq_active !== expected_head.irq_active)
                    begin
                        $display("%0t: irq_active mismatch expected=%0b actual=%0b",
                                 $time, expected_head.irq_active, out_item.irq_active);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int         kind;
        int         span;
        bit         make_periodic;
        logic [7:0] lo;
        logic [7:0] mask_val;

        // reset values, fixed reads, vector, mode other than 3/6, restart,
        // zero preload, status clear-on-read, line drop, expiry with mask clear
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_MASK, 8'h00);
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_ONE, 8'hff);
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_IACK, 8'h00);
        queue_item(ctiu_pkg::CMD_READ, 4'h0, 8'h00);
        queue_item(ctiu_pkg::CMD_ACK, 4'hf, 8'hff);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_VECTOR, 8'hff);
        queue_item(ctiu_pkg::CMD_ACK, 4'h0, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_MASK, 8'hff);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_HI, 8'hff);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_LO, 8'hff);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, 8'hb0);
        queue_item(ctiu_pkg::CMD_TICK, 4'h0, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, 8'h70);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_HI, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_PRE_LO, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, 8'h6f);
        queue_item(ctiu_pkg::CMD_TICK, 4'hf, 8'hff);
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_MASK, 8'h00);
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_MASK, 8'h00);
        queue_item(ctiu_pkg::CMD_ACK, 4'h0, 8'h00);
        queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_IACK, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_MASK, 8'hf7);
        queue_item(ctiu_pkg::CMD_TICK, 4'h0, 8'h00);
        queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, 8'h30);
        queue_item(ctiu_pkg::CMD_TICK, 4'h0, 8'h00);

        while (pending_items.size() < TOTAL_ITEMS)
        begin
            kind = $urandom_range(9);
            if (kind <= 6)
            begin
                if ($urandom_range(1))
                begin
                    mask_val = 8'($urandom);
                    mask_val[ctiu_pkg::MASK_TIMER_BIT] = ($urandom_range(3) != 0);
                    queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_MASK, mask_val);
                end
                make_periodic = ($urandom_range(3) != 0);
                if (make_periodic)
                    lo = 8'($urandom_range(3));
                else
                    lo = ($urandom_range(4) == 0) ? 8'd1 : 8'd0;
                queue_timer_start(make_periodic, lo);
                span = make_periodic ? ctiu_pkg::PERIODIC_SCALE * lo
                                     : ctiu_pkg::ONE_SHOT_SCALE * lo;
                queue_ticks(span + $urandom_range(span + 2) + 1);
                queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_MASK, 8'($urandom));
                if ($urandom_range(1))
                    queue_item(ctiu_pkg::CMD_ACK, 4'($urandom), 8'($urandom));
                queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_IACK, 8'($urandom));
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 6)) queue_noise();
            end
            else if (kind == 8)
            begin
                // cut short: drop the line early or rewrite the mode mid-count
                queue_timer_start(1'($urandom_range(1)), 8'($urandom_range(1, 3)));
                queue_ticks($urandom_range(1, 6));
                if ($urandom_range(1))
                    queue_item(ctiu_pkg::CMD_READ, ctiu_pkg::OFF_IACK, 8'($urandom));
                else
                    queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_ACR, 8'($urandom));
            end
            else
            begin
                queue_item(ctiu_pkg::CMD_WRITE, ctiu_pkg::OFF_VECTOR, 8'($urandom));
                queue_item(ctiu_pkg::CMD_ACK, 4'($urandom), 8'($urandom));
                queue_item(ctiu_pkg::CMD_READ, 4'($urandom), 8'($urandom));
            end
        end
        total_items = pending_items.size();

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ctiu_pkg.sv
hdl/ctiu_timer.sv
hdl/ctiu_intr.sv
hdl/counter_timer_interrupt_unit_core.sv
hdl/ctiu_checker.sv
tb/sv/tb_counter_timer_interrupt_unit_core.sv
